// ===== sv/jsu_pkg.sv =====
// Shared types and constants for the JSON string literal decoder.
package jsu_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_DONE,
        KIND_ERR
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX0,
        PH_HEX1,
        PH_HEX2,
        PH_HEX3,
        PH_LBS,
        PH_LU,
        PH_LHEX0,
        PH_LHEX1,
        PH_LHEX2,
        PH_LHEX3
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // One decoded unit: a code point with its UTF-8 length less one, or a status.
    typedef struct packed {
        t_kind       kind;
        logic [20:0] cp;
        logic [1:0]  cnt;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_flow;

endpackage

// ===== sv/jsu_front.sv =====
// Front end: accepts text bytes, tracks escapes and surrogates, and issues commands.
module jsu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  jsu_pkg::t_in_item  i_item,
    input  logic               i_full,
    output logic               o_stall,
    output jsu_pkg::t_cmd_flow o_push
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    jsu_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_acc, n_acc;
    logic [9:0]      r_hs, n_hs;

    logic            s_accept;
    logic [7:0]      s_c;
    logic [4:0]      s_digit;
    logic [15:0]     s_acc_next;
    logic            s_is_high;
    logic            s_is_low;
    logic [20:0]     s_pair_cp;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
        return v;
    endfunction

    function automatic logic [1:0] utf8_cnt(input logic [20:0] cp);
        logic [1:0] n;
        if (cp < 21'h80) n = 2'd0;
        else if (cp < 21'h800) n = 2'd1;
        else if (cp < 21'h10000) n = 2'd2;
        else n = 2'd3;
        return n;
    endfunction

    assign o_stall    = i_full;
    assign s_accept   = i_valid && !i_full;
    assign s_c        = i_item.in_byte;
    assign s_digit    = hex_value(s_c);
    assign s_acc_next = {r_acc[11:0], s_digit[3:0]};
    assign s_is_high  = (s_acc_next[15:10] == 6'b110110);
    assign s_is_low   = (s_acc_next[15:10] == 6'b110111);
    assign s_pair_cp  = 21'h10000 + {1'b0, r_hs, s_acc_next[9:0]};

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_hs    = r_hs;
        if (i_item.end_of_text) begin
            n_phase = jsu_pkg::PH_IDLE;
        end else begin
            unique case (r_phase)
                jsu_pkg::PH_IDLE: begin
                    if (s_c == CH_QUOTE) n_phase = jsu_pkg::PH_BODY;
                end
                jsu_pkg::PH_BODY: begin
                    if (s_c == CH_QUOTE) n_phase = jsu_pkg::PH_IDLE;
                    else if (s_c == CH_BSL) n_phase = jsu_pkg::PH_ESC;
                    else if (s_c < 8'h20) n_phase = jsu_pkg::PH_IDLE;
                end
                jsu_pkg::PH_ESC: begin
                    if (s_c == CH_U) begin
                        n_phase = jsu_pkg::PH_HEX0;
                        n_acc   = '0;
                    end else if (s_c == CH_QUOTE || s_c == CH_BSL || s_c == CH_SLASH ||
                                 s_c == CH_B || s_c == CH_F || s_c == CH_N ||
                                 s_c == CH_R || s_c == CH_T) begin
                        n_phase = jsu_pkg::PH_BODY;
                    end else begin
                        n_phase = jsu_pkg::PH_IDLE;
                    end
                end
                jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2,
                jsu_pkg::PH_LHEX0, jsu_pkg::PH_LHEX1, jsu_pkg::PH_LHEX2: begin
                    if (s_digit[4]) begin
                        n_phase = jsu_pkg::PH_IDLE;
                    end else begin
                        n_acc   = s_acc_next;
                        n_phase = jsu_pkg::t_phase'(r_phase + 4'd1);
                    end
                end
                jsu_pkg::PH_HEX3: begin
                    n_acc = s_acc_next;
                    if (s_digit[4] || s_is_low) begin
                        n_phase = jsu_pkg::PH_IDLE;
                    end else if (s_is_high) begin
                        n_phase = jsu_pkg::PH_LBS;
                        n_hs    = s_acc_next[9:0];
                    end else begin
                        n_phase = jsu_pkg::PH_BODY;
                    end
                end
                jsu_pkg::PH_LHEX3: begin
                    n_acc = s_acc_next;
                    if (s_digit[4] || !s_is_low) n_phase = jsu_pkg::PH_IDLE;
                    else n_phase = jsu_pkg::PH_BODY;
                end
                jsu_pkg::PH_LBS: begin
                    n_phase = (s_c == CH_BSL) ? jsu_pkg::PH_LU : jsu_pkg::PH_IDLE;
                end
                jsu_pkg::PH_LU: begin
                    if (s_c == CH_U) begin
                        n_phase = jsu_pkg::PH_LHEX0;
                        n_acc   = '0;
                    end else begin
                        n_phase = jsu_pkg::PH_IDLE;
                    end
                end
                default: n_phase = jsu_pkg::PH_IDLE;
            endcase
        end
    end

    always_comb begin
        o_push.valid    = 1'b0;
        o_push.cmd.kind = jsu_pkg::KIND_ERR;
        o_push.cmd.cp   = '0;
        o_push.cmd.cnt  = '0;
        if (i_item.end_of_text) begin
            o_push.valid = 1'b1;
        end else begin
            unique case (r_phase)
                jsu_pkg::PH_IDLE: begin
                    o_push.valid = (s_c != CH_QUOTE);
                end
                jsu_pkg::PH_BODY: begin
                    if (s_c == CH_QUOTE) begin
                        o_push.valid    = 1'b1;
                        o_push.cmd.kind = jsu_pkg::KIND_DONE;
                    end else if (s_c == CH_BSL) begin
                        o_push.valid = 1'b0;
                    end else if (s_c < 8'h20) begin
                        o_push.valid = 1'b1;
                    end else begin
                        o_push.valid    = 1'b1;
                        o_push.cmd.kind = jsu_pkg::KIND_BYTE;
                        o_push.cmd.cp   = {13'd0, s_c};
                    end
                end
                jsu_pkg::PH_ESC: begin
                    o_push.valid    = (s_c != CH_U);
                    o_push.cmd.kind = jsu_pkg::KIND_BYTE;
                    unique case (s_c)
                        CH_QUOTE, CH_BSL, CH_SLASH: o_push.cmd.cp = {13'd0, s_c};
                        CH_B: o_push.cmd.cp = 21'h08;
                        CH_F: o_push.cmd.cp = 21'h0C;
                        CH_N: o_push.cmd.cp = 21'h0A;
                        CH_R: o_push.cmd.cp = 21'h0D;
                        CH_T: o_push.cmd.cp = 21'h09;
                        CH_U: o_push.cmd.cp = '0;
                        default: o_push.cmd.kind = jsu_pkg::KIND_ERR;
                    endcase
                end
                jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2,
                jsu_pkg::PH_LHEX0, jsu_pkg::PH_LHEX1, jsu_pkg::PH_LHEX2: begin
                    o_push.valid = s_digit[4];
                end
                jsu_pkg::PH_HEX3: begin
                    if (s_digit[4] || s_is_low) begin
                        o_push.valid = 1'b1;
                    end else if (!s_is_high) begin
                        o_push.valid    = 1'b1;
                        o_push.cmd.kind = jsu_pkg::KIND_BYTE;
                        o_push.cmd.cp   = {5'd0, s_acc_next};
                        o_push.cmd.cnt  = utf8_cnt({5'd0, s_acc_next});
                    end
                end
                jsu_pkg::PH_LHEX3: begin
                    o_push.valid = 1'b1;
                    if (!s_digit[4] && s_is_low) begin
                        o_push.cmd.kind = jsu_pkg::KIND_BYTE;
                        o_push.cmd.cp   = s_pair_cp;
                        o_push.cmd.cnt  = 2'd3;
                    end
                end
                jsu_pkg::PH_LBS: o_push.valid = (s_c != CH_BSL);
                jsu_pkg::PH_LU:  o_push.valid = (s_c != CH_U);
                default:         o_push.valid = 1'b1;
            endcase
        end
        o_push.valid = o_push.valid && s_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsu_pkg::PH_IDLE;
            r_acc   <= '0;
            r_hs    <= '0;
        end else if (s_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_hs    <= n_hs;
        end
    end

endmodule

// ===== sv/jsu_queue.sv =====
// Short command queue between the front end and the byte emitter.
module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jsu_pkg::t_cmd_flow i_push,
    input  logic               i_pop,
    output logic               o_full,
    output jsu_pkg::t_cmd_flow o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             s_push;
    logic             s_pop;

    assign o_full      = (r_cnt == CNT_W'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd];
    assign s_push      = i_push.valid && !o_full;
    assign s_pop       = i_pop && o_head.valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (s_push) n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (s_pop)  n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (s_push && !s_pop) n_cnt = r_cnt + 1'b1;
        else if (s_pop && !s_push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (s_push) r_mem[r_wr] <= i_push.cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== sv/jsu_back.sv =====
// Back end: expands queued commands into UTF-8 result items, one per cycle unless stalled.
module jsu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jsu_pkg::t_cmd_flow i_head,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output jsu_pkg::t_out_item o_item
);

    logic               r_valid;
    jsu_pkg::t_out_item r_item, n_item;
    logic [1:0]         r_pos, n_pos;
    logic               s_load;
    logic               s_end;

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] cnt,
                                             input logic [1:0] pos);
        logic [7:0] b;
        logic [1:0] rem;
        rem = cnt - pos;
        if (pos == 2'd0) begin
            unique case (cnt)
                2'd0: b = cp[7:0];
                2'd1: b = {3'b110, cp[10:6]};
                2'd2: b = {4'b1110, cp[15:12]};
                2'd3: b = {5'b11110, cp[20:18]};
                default: b = '0;
            endcase
        end else begin
            unique case (rem)
                2'd0: b = {2'b10, cp[5:0]};
                2'd1: b = {2'b10, cp[11:6]};
                2'd2: b = {2'b10, cp[17:12]};
                default: b = '0;
            endcase
        end
        return b;
    endfunction

    assign s_load  = !r_valid || !i_stall;
    assign s_end   = (r_pos == i_head.cmd.cnt);
    assign o_pop   = s_load && i_head.valid && s_end;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.kind     = i_head.cmd.kind;
        n_item.last     = s_end;
        n_item.out_byte = '0;
        if (i_head.cmd.kind == jsu_pkg::KIND_BYTE) begin
            n_item.out_byte = utf8_byte(i_head.cmd.cp, i_head.cmd.cnt, r_pos);
        end
        n_pos = r_pos;
        if (s_load && i_head.valid) n_pos = s_end ? 2'd0 : r_pos + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (s_load) r_item <= n_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            if (s_load) r_valid <= i_head.valid;
            r_pos <= n_pos;
        end
    end

endmodule

// ===== sv/json_string_unescape_utf8.sv =====
// Top level of the JSON string literal decoder with UTF-8 output.
//
// The input channel takes one byte of text per item (i_valid, o_stall, i_item).
// An item whose end_of_text bit is set carries no byte and ends the literal.
// The output channel (o_valid, i_stall, o_item) gives decoded UTF-8 bytes, a
// completion item at the closing quote, or an error item for a malformed literal.
// Each input item causes zero to four result items; the last of them has last set.
// An item is taken in every cycle while the command queue has room, so the front
// end runs at one byte per cycle. The emitter gives one result item per cycle
// unless the receiver stalls; a \u escape yielding several UTF-8 bytes gives each
// as its own item. A result is registered in the queue and then the output register.
// When the receiver stalls, the output register holds its item, the queue of
// P_QUEUE_DEPTH commands fills, and then o_stall rises towards the sender.
// Reset returns the decoder to idle, awaiting an opening quote, and empties the
// queue and the output register.
module json_string_unescape_utf8 #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  jsu_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output jsu_pkg::t_out_item o_item
);

    jsu_pkg::t_cmd_flow s_push;
    jsu_pkg::t_cmd_flow s_head;
    logic               s_full;
    logic               s_pop;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_full  (s_full),
        .o_stall (o_stall),
        .o_push  (s_push)
    );

    jsu_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_pop   (s_pop),
        .o_full  (s_full),
        .o_head  (s_head)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (s_head),
        .o_pop   (s_pop),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push.valid |-> !s_full)
        else $error("Command pushed into a full queue.");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |-> s_head.valid)
        else $error("Command popped from an empty queue.");

    a_status_item_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.kind != jsu_pkg::KIND_BYTE) |->
            (o_item.last && o_item.out_byte == 8'h00))
        else $error("Status item without last or with a non-zero byte.");

endmodule

// ===== sim/tb_json_string_unescape_utf8.sv =====
// Self-checking testbench for the JSON string literal decoder with UTF-8 output.
module tb_json_string_unescape_utf8;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    jsu_pkg::t_in_item  i_item  = '0;
    logic               o_stall;
    logic               o_valid;
    jsu_pkg::t_out_item o_item;

    jsu_pkg::t_out_item decoded_q[$];
    jsu_pkg::t_phase    ph      = jsu_pkg::PH_IDLE;
    logic [15:0]        hex_acc = '0;
    logic [9:0]         hi_bits = '0;

    int mismatches     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int literals_begun = 0;
    int stall_left     = 0;
    bit tx_quiet       = 1'b0;
    bit rx_quiet       = 1'b0;
    bit rx_heavy       = 1'b0;

    json_string_unescape_utf8 uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return 16;
    endfunction

    function automatic bit is_escape_char(input logic [7:0] c);
        return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_U ||
               c == "b" || c == "f" || c == "n" || c == "r" || c == "t";
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic jsu_pkg::t_out_item data_item(input logic [7:0] b);
        return '{kind: jsu_pkg::KIND_BYTE, out_byte: b, last: 1'b0};
    endfunction

    // Works out the results of one accepted item and queues them.
    task automatic decode_step(input jsu_pkg::t_in_item it);
        jsu_pkg::t_out_item res [4];
        int                 n;
        int                 d;
        bit                 bad;
        bit                 emit;
        logic [20:0]        cp;
        logic [7:0]         c;
        n    = 0;
        c    = it.in_byte;
        bad  = it.end_of_text;
        emit = 1'b0;
        cp   = '0;
        if (!bad) begin
            case (ph)
                jsu_pkg::PH_BODY: begin
                    if (c == CH_QUOTE) begin
                        ph = jsu_pkg::PH_IDLE;
                        res[0] = '{kind: jsu_pkg::KIND_DONE, out_byte: 8'h00, last: 1'b0};
                        n = 1;
                    end else if (c == CH_BSLASH) begin
                        ph = jsu_pkg::PH_ESC;
                    end else if (c < 8'h20) begin
                        bad = 1'b1;
                    end else begin
                        res[0] = data_item(c);
                        n = 1;
                    end
                end
                jsu_pkg::PH_ESC: begin
                    if (c == CH_U) begin
                        hex_acc = '0;
                        ph = jsu_pkg::PH_HEX0;
                    end else if (!is_escape_char(c)) begin
                        bad = 1'b1;
                    end else begin
                        case (c)
                            "b":     c = 8'h08;
                            "f":     c = 8'h0C;
                            "n":     c = 8'h0A;
                            "r":     c = 8'h0D;
                            "t":     c = 8'h09;
                            default: c = c;
                        endcase
                        ph = jsu_pkg::PH_BODY;
                        res[0] = data_item(c);
                        n = 1;
                    end
                end
                jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3,
                jsu_pkg::PH_LHEX0, jsu_pkg::PH_LHEX1, jsu_pkg::PH_LHEX2,
                jsu_pkg::PH_LHEX3: begin
                    d = hex_nibble(c);
                    if (d > 15) begin
                        bad = 1'b1;
                    end else begin
                        hex_acc = {hex_acc[11:0], d[3:0]};
                        if (ph != jsu_pkg::PH_HEX3 && ph != jsu_pkg::PH_LHEX3) begin
                            ph = jsu_pkg::t_phase'(ph + 1);
                        end else if (ph == jsu_pkg::PH_HEX3) begin
                            if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                                hi_bits = hex_acc[9:0];
                                ph = jsu_pkg::PH_LBS;
                            end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                                bad = 1'b1;
                            end else begin
                                cp = {5'd0, hex_acc};
                                emit = 1'b1;
                            end
                        end else begin
                            if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                                bad = 1'b1;
                            end else begin
                                cp = 21'h10000 + {1'b0, hi_bits, hex_acc[9:0]};
                                hi_bits = '0;
                                emit = 1'b1;
                            end
                        end
                    end
                end
                jsu_pkg::PH_LBS: begin
                    if (c != CH_BSLASH) bad = 1'b1;
                    else ph = jsu_pkg::PH_LU;
                end
                jsu_pkg::PH_LU: begin
                    if (c != CH_U) begin
                        bad = 1'b1;
                    end else begin
                        hex_acc = '0;
                        ph = jsu_pkg::PH_LHEX0;
                    end
                end
                default: begin
                    if (c != CH_QUOTE) begin
                        bad = 1'b1;
                    end else begin
                        ph = jsu_pkg::PH_BODY;
                        hex_acc = '0;
                        hi_bits = '0;
                    end
                end
            endcase
        end
        if (bad) begin
            ph = jsu_pkg::PH_IDLE;
            hex_acc = '0;
            hi_bits = '0;
            res[0] = '{kind: jsu_pkg::KIND_ERR, out_byte: 8'h00, last: 1'b0};
            n = 1;
        end
        if (emit) begin
            ph = jsu_pkg::PH_BODY;
            if (cp < 21'h80) begin
                res[0] = data_item(cp[7:0]);
                n = 1;
            end else if (cp < 21'h800) begin
                res[0] = data_item({3'b110, cp[10:6]});
                res[1] = data_item({2'b10, cp[5:0]});
                n = 2;
            end else if (cp < 21'h10000) begin
                res[0] = data_item({4'b1110, cp[15:12]});
                res[1] = data_item({2'b10, cp[11:6]});
                res[2] = data_item({2'b10, cp[5:0]});
                n = 3;
            end else begin
                res[0] = data_item({5'b11110, cp[20:18]});
                res[1] = data_item({2'b10, cp[17:12]});
                res[2] = data_item({2'b10, cp[11:6]});
                res[3] = data_item({2'b10, cp[5:0]});
                n = 4;
            end
        end
        if (n > 0) begin
            res[n - 1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            decoded_q.insert(decoded_q.size(), res[i]);
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic eot);
        int gap;
        gap = (!tx_quiet && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            i_item  = '{in_byte: 8'($urandom), end_of_text: 1'($urandom)};
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_item  = '{in_byte: b, end_of_text: eot};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        decode_step(i_item);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
    endtask

    task automatic send_eot();
        send_item(8'($urandom), 1'b1);
    endtask

    task automatic send_esc(input logic [7:0] c);
        send_item(CH_BSLASH, 1'b0);
        send_item(c, 1'b0);
    endtask

    task automatic send_u(input logic [15:0] v);
        send_esc(CH_U);
        for (int k = 3; k >= 0; k--) begin
            send_item(hex_char(v[4 * k +: 4], 1'($urandom)), 1'b0);
        end
    endtask

    task automatic open_literal();
        send_item(CH_QUOTE, 1'b0);
        literals_begun++;
    endtask

    // The sender holds off until every queued result has been delivered.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_plain_and_framing();
        open_literal();
        send_item(8'h20, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        open_literal();
        send_item(8'h1F, 1'b0);
        send_item("x", 1'b0);
        send_eot();
        open_literal();
        send_item(8'h00, 1'b0);
        open_literal();
        send_text("a");
        send_eot();
    endtask

    task automatic test_simple_escapes();
        open_literal();
        send_esc(CH_QUOTE);
        send_esc(CH_BSLASH);
        send_esc(CH_SLASH);
        send_esc("b");
        send_esc("f");
        send_esc("n");
        send_esc("r");
        send_esc("t");
        send_esc("x");
    endtask

    task automatic test_unicode_escapes();
        open_literal();
        send_u(16'h0000);
        send_u(16'h007F);
        send_u(16'h0080);
        send_u(16'h07FF);
        send_u(16'h0800);
        send_u(16'hFFFF);
        send_u(16'hD800);
        send_u(16'hDC00);
        send_u(16'hDBFF);
        send_u(16'hDFFF);
        send_item(CH_QUOTE, 1'b0);
        open_literal();
        send_esc(CH_U);
        send_text("1g");
        open_literal();
        send_u(16'hDC00);
        open_literal();
        send_u(16'hD800);
        send_text("a");
        open_literal();
        send_u(16'hDBFF);
        send_esc("n");
        open_literal();
        send_u(16'hD800);
        send_u(16'h0041);
        open_literal();
        send_u(16'hD801);
        send_esc(CH_U);
        send_text("DC0z");
    endtask

    task automatic send_random_code_point();
        case ($urandom_range(0, 3))
            0:       send_u(16'($urandom_range(16'h0000, 16'h007F)));
            1:       send_u(16'($urandom_range(16'h0080, 16'h07FF)));
            2:       send_u(16'($urandom_range(16'h0800, 16'hD7FF)));
            default: send_u(16'($urandom_range(16'hE000, 16'hFFFF)));
        endcase
    endtask

    // One malformed construct; the decoder is idle afterwards.
    task automatic send_broken();
        logic [7:0] b;
        case ($urandom_range(0, 6))
            0: send_item(8'($urandom_range(0, 31)), 1'b0);
            1: send_eot();
            2: begin
                b = 8'($urandom);
                while (is_escape_char(b)) b = 8'($urandom);
                send_esc(b);
            end
            3, 6: begin
                send_esc(CH_U);
                repeat ($urandom_range(0, 3)) send_item(hex_char(4'($urandom), 1'($urandom)), 1'b0);
                b = 8'($urandom);
                while (hex_nibble(b) < 16) b = 8'($urandom);
                send_item(b, 1'b0);
            end
            4: send_u(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
            default: begin
                send_u(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
                case ($urandom_range(0, 2))
                    0: begin
                        b = 8'($urandom);
                        while (b == CH_BSLASH) b = 8'($urandom);
                        send_item(b, 1'b0);
                    end
                    1: begin
                        b = 8'($urandom);
                        while (b == CH_U) b = 8'($urandom);
                        send_esc(b);
                    end
                    default: begin
                        if ($urandom_range(0, 1) == 0) begin
                            send_u(16'($urandom_range(16'h0000, 16'hDBFF)));
                        end else begin
                            send_u(16'($urandom_range(16'hE000, 16'hFFFF)));
                        end
                    end
                endcase
            end
        endcase
    endtask

    task automatic send_random_literal();
        logic [7:0] b;
        int         segs;
        int         broken_at;
        if ($urandom_range(0, 99) < 8) begin
            if ($urandom_range(0, 3) == 0) send_eot();
            else send_item(8'($urandom), 1'b0);
        end
        open_literal();
        segs      = $urandom_range(0, 8);
        broken_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, segs) : -1;
        for (int s = 0; s <= segs; s++) begin
            if (s == broken_at) begin
                send_broken();
                return;
            end
            if (s == segs) break;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    b = 8'($urandom_range(8'h20, 8'hFF));
                    while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(8'h20, 8'hFF));
                    send_item(b, 1'b0);
                end
                5: begin
                    b = 8'($urandom);
                    while (!is_escape_char(b) || b == CH_U) b = 8'($urandom);
                    send_esc(b);
                end
                6, 7: send_random_code_point();
                default: begin
                    send_u(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
                    send_u(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
                end
            endcase
        end
        send_item(CH_QUOTE, 1'b0);
    endtask

    task automatic test_random_literals(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            send_random_literal();
            if ($urandom_range(0, 5) == 0) wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        test_random_literals(30);
        rx_quiet = 1'b0;
        wait_drained();
    endtask

    task automatic test_receiver_backpressure();
        rx_heavy = 1'b1;
        test_random_literals(30);
        tx_quiet = 1'b0;
        rx_heavy = 1'b0;
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall = 1'b1;
        end else if (!rx_quiet && $urandom_range(0, 99) < (rx_heavy ? 50 : 20)) begin
            stall_left = gap_len() - 1;
            i_stall = 1'b1;
        end else begin
            i_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        jsu_pkg::t_out_item want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            results_seen++;
            if (decoded_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %p", $time, o_item);
            end else begin
                want = decoded_q.pop_front();
                if (o_item.kind !== want.kind) begin
                    mismatches++;
                    $display("%0t: kind mismatch, expected %0d, actual %0d",
                             $time, want.kind, o_item.kind);
                end
                if (o_item.out_byte !== want.out_byte) begin
                    mismatches++;
                    $display("%0t: out_byte mismatch, expected 0x%02h, actual 0x%02h",
                             $time, want.out_byte, o_item.out_byte);
                end
                if (o_item.last !== want.last) begin
                    mismatches++;
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, o_item.last);
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_plain_and_framing();
        test_simple_escapes();
        test_unicode_escapes();
        wait_drained();
        test_random_literals(50);
        test_back_to_back();
        test_receiver_backpressure();
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d text items over %0d literals, including escapes and surrogates,",
                 items_sent, literals_begun);
        $display("and checked %0d decoded results with %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout: %0d results still outstanding.", decoded_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
